FILE: rtl/id3_pkg.sv
package id3_pkg;

  localparam int HEADER_LEN = 10;
  localparam int TAG_MAX    = 5;
  localparam int NAME_MAX   = 32;

  localparam logic [11:0] REGION_RESET = 12'd470;
  localparam logic [11:0] COUNT_MAX    = 12'hFFF;
  localparam logic [7:0]  KEPT_MAX     = 8'hFF;

  localparam logic [1:0] KIND_TITLE  = 2'd0;
  localparam logic [1:0] KIND_ARTIST = 2'd1;
  localparam logic [1:0] KIND_GENRE  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] FORM_TEXT   = 2'd0;
  localparam logic [1:0] FORM_TWO    = 2'd1;
  localparam logic [1:0] FORM_ONE    = 2'd2;

  localparam logic [39:0] TAG_TT2 = 40'h000032_5454;
  localparam logic [39:0] TAG_TP1 = 40'h000031_5054;
  localparam logic [39:0] TAG_TCO = 40'h00004F_4354;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_TAG     = 7'b0000010,
    PH_SKIP    = 7'b0000100,
    PH_OPTZERO = 7'b0001000,
    PH_SIZE    = 7'b0010000,
    PH_CONTENT = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] field_kind;
    logic [4:0] char_pos;
    logic [7:0] char_value;
    logic       is_end;
    logic       keep;
    logic [7:0] kept_length;
    logic [1:0] genre_form;
    logic [6:0] genre_id;
  } out_rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [1:0] match_tag(input logic [2:0] len, input logic [39:0] chars);
    logic [1:0] k;
    k = KIND_NONE;
    if (len == 3'd3) begin
      if (chars == TAG_TT2) k = KIND_TITLE;
      else if (chars == TAG_TP1) k = KIND_ARTIST;
      else if (chars == TAG_TCO) k = KIND_GENRE;
    end
    return k;
  endfunction

  function automatic out_rec_t end_record(input logic [1:0] kind, input logic [7:0] kept,
                                          input logic [31:0] ff);
    out_rec_t   r;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    logic [6:0] d1;
    logic [6:0] d2;
    c0 = ff[7:0];
    c1 = ff[15:8];
    c2 = ff[23:16];
    c3 = ff[31:24];
    d1 = {3'd0, c1[3:0]};
    d2 = {3'd0, c2[3:0]};
    r = '0;
    r.field_kind  = kind;
    r.is_end      = 1'b1;
    r.keep        = (kept >= 8'd2);
    r.kept_length = kept;
    if (kind == KIND_GENRE && c0 == 8'h28 && is_digit(c1)) begin
      if (is_digit(c2) && c3 == 8'h29) begin
        r.genre_form = FORM_TWO;
        r.genre_id   = (d1 << 3) + (d1 << 1) + d2;
      end else if (c2 == 8'h29) begin
        r.genre_form = FORM_ONE;
        r.genre_id   = d1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/id3_tag_field_extractor.sv
// ID3 tag field extractor: takes one file byte per transaction, skips the
// 10-byte header and walks tag frames until cfg region_bytes bytes are used,
// emitting title/artist/genre characters and one end record per matched frame.
// All per-byte work is done in the accepting cycle, so one byte is taken every
// unstalled clock. A byte can produce two results (last printable character of
// a frame plus its end record); results drain through a 4-entry queue at one
// per unstalled clock, and in_stall rises when fewer than two slots are free.
module id3_tag_field_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_field_kind,
  output logic [4:0]  out_char_pos,
  output logic [7:0]  out_char_value,
  output logic        out_is_end,
  output logic        out_keep,
  output logic [7:0]  out_kept_length,
  output logic [1:0]  out_genre_form,
  output logic [6:0]  out_genre_id
);

  logic [11:0]      region_r;
  id3_pkg::phase_t  phase_r, phase_nxt;
  logic [11:0]      bc_r, bc_nxt;
  logic [39:0]      tag_r, tag_nxt;
  logic [2:0]       tag_len_r, tag_len_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [7:0]       kept_r, kept_nxt;
  logic [31:0]      ff_r, ff_nxt;
  logic [1:0]       kind_r, kind_nxt;

  id3_pkg::out_rec_t q_r [id3_pkg::OQ_DEPTH];
  logic [id3_pkg::OQ_AW-1:0] wr_r, rd_r;
  logic [id3_pkg::OQ_CW-1:0] cnt_r, cnt_nxt;

  logic              acc, pop;
  logic              chr_vld, end_vld;
  id3_pkg::out_rec_t chr_rec, end_rec;
  logic [7:0]        b;
  logic [7:0]        pos;
  logic [1:0]        n_push;

  assign b        = in_data_byte;
  assign in_stall = (cnt_r > id3_pkg::OQ_CW'(id3_pkg::OQ_DEPTH - 2));
  assign acc      = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign pop      = out_valid && !out_stall;

  always_comb begin
    phase_nxt   = phase_r;
    bc_nxt      = bc_r;
    tag_nxt     = tag_r;
    tag_len_nxt = tag_len_r;
    left_nxt    = left_r;
    kept_nxt    = kept_r;
    ff_nxt      = ff_r;
    kind_nxt    = kind_r;
    chr_vld     = 1'b0;
    end_vld     = 1'b0;
    chr_rec     = '0;
    end_rec     = '0;
    pos         = kept_r;
    if (in_start_of_file) begin
      phase_nxt   = id3_pkg::PH_HEADER;
      bc_nxt      = '0;
      tag_nxt     = '0;
      tag_len_nxt = '0;
      left_nxt    = '0;
      kept_nxt    = '0;
      ff_nxt      = '0;
      kind_nxt    = id3_pkg::KIND_NONE;
    end
    if (phase_nxt == id3_pkg::PH_DONE) begin
    end else if (phase_nxt == id3_pkg::PH_TAG && tag_len_nxt == '0 && bc_nxt >= region_r) begin
      phase_nxt = id3_pkg::PH_DONE;
    end else begin
      case (phase_nxt)
        id3_pkg::PH_HEADER: begin
          if (bc_nxt >= 12'(id3_pkg::HEADER_LEN - 1)) phase_nxt = id3_pkg::PH_TAG;
        end
        id3_pkg::PH_TAG: begin
          if (b == 8'd0) begin
            phase_nxt = id3_pkg::PH_OPTZERO;
          end else begin
            tag_nxt[{tag_len_nxt, 3'b000} +: 8] = b;
            tag_len_nxt = tag_len_nxt + 3'd1;
            if (tag_len_nxt >= 3'(id3_pkg::TAG_MAX)) phase_nxt = id3_pkg::PH_SKIP;
          end
        end
        id3_pkg::PH_SKIP: begin
          phase_nxt = id3_pkg::PH_OPTZERO;
        end
        id3_pkg::PH_OPTZERO, id3_pkg::PH_SIZE: begin
          if (phase_nxt == id3_pkg::PH_OPTZERO && b == 8'd0) begin
            phase_nxt = id3_pkg::PH_SIZE;
          end else begin
            kind_nxt = id3_pkg::match_tag(tag_len_nxt, tag_nxt);
            if (b == 8'd0) begin
              end_vld     = (kind_nxt != id3_pkg::KIND_NONE);
              end_rec     = id3_pkg::end_record(kind_nxt, kept_nxt, ff_nxt);
              tag_nxt     = '0;
              tag_len_nxt = '0;
              left_nxt    = '0;
              kept_nxt    = '0;
              ff_nxt      = '0;
              kind_nxt    = id3_pkg::KIND_NONE;
              phase_nxt   = id3_pkg::PH_TAG;
            end else begin
              left_nxt  = b;
              phase_nxt = id3_pkg::PH_CONTENT;
            end
          end
        end
        id3_pkg::PH_CONTENT: begin
          pos = kept_nxt;
          if (b inside {[8'h20:8'h7E]}) begin
            if (pos < 8'd4) ff_nxt[{pos[1:0], 3'b000} +: 8] = b;
            if (kept_nxt != id3_pkg::KEPT_MAX) kept_nxt = kept_nxt + 8'd1;
            if (kind_nxt != id3_pkg::KIND_NONE && pos < 8'(id3_pkg::NAME_MAX)) begin
              chr_vld = 1'b1;
              chr_rec.field_kind  = kind_nxt;
              chr_rec.char_pos    = pos[4:0];
              chr_rec.char_value  = b;
              chr_rec.kept_length = kept_nxt;
            end
          end
          if (left_nxt != 8'd0) left_nxt = left_nxt - 8'd1;
          if (left_nxt == 8'd0) begin
            end_vld     = (kind_nxt != id3_pkg::KIND_NONE);
            end_rec     = id3_pkg::end_record(kind_nxt, kept_nxt, ff_nxt);
            tag_nxt     = '0;
            tag_len_nxt = '0;
            kept_nxt    = '0;
            ff_nxt      = '0;
            kind_nxt    = id3_pkg::KIND_NONE;
            phase_nxt   = id3_pkg::PH_TAG;
          end
        end
        default: begin
          phase_nxt = id3_pkg::PH_DONE;
        end
      endcase
      if (bc_nxt != id3_pkg::COUNT_MAX) bc_nxt = bc_nxt + 12'd1;
    end
  end

  assign n_push  = acc ? (2'(chr_vld) + 2'(end_vld)) : 2'd0;
  assign cnt_nxt = cnt_r + id3_pkg::OQ_CW'(n_push) - id3_pkg::OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r  <= id3_pkg::REGION_RESET;
      phase_r   <= id3_pkg::PH_HEADER;
      bc_r      <= '0;
      tag_r     <= '0;
      tag_len_r <= '0;
      left_r    <= '0;
      kept_r    <= '0;
      ff_r      <= '0;
      kind_r    <= id3_pkg::KIND_NONE;
      wr_r      <= '0;
      rd_r      <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_wr_en) region_r <= cfg_wr_data;
      if (acc) begin
        phase_r   <= phase_nxt;
        bc_r      <= bc_nxt;
        tag_r     <= tag_nxt;
        tag_len_r <= tag_len_nxt;
        left_r    <= left_nxt;
        kept_r    <= kept_nxt;
        ff_r      <= ff_nxt;
        kind_r    <= kind_nxt;
      end
      wr_r  <= wr_r + id3_pkg::OQ_AW'(n_push);
      rd_r  <= rd_r + id3_pkg::OQ_AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (chr_vld) begin
        q_r[wr_r] <= chr_rec;
        if (end_vld) q_r[wr_r + id3_pkg::OQ_AW'(1)] <= end_rec;
      end else if (end_vld) begin
        q_r[wr_r] <= end_rec;
      end
    end
  end

  assign out_field_kind  = q_r[rd_r].field_kind;
  assign out_char_pos    = q_r[rd_r].char_pos;
  assign out_char_value  = q_r[rd_r].char_value;
  assign out_is_end      = q_r[rd_r].is_end;
  assign out_keep        = q_r[rd_r].keep;
  assign out_kept_length = q_r[rd_r].kept_length;
  assign out_genre_form  = q_r[rd_r].genre_form;
  assign out_genre_id    = q_r[rd_r].genre_id;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= id3_pkg::OQ_CW'(id3_pkg::OQ_DEPTH))
    else $error("result queue overfilled");

  a_keep_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_end && out_keep) |-> (out_kept_length >= 8'd2))
    else $error("field committed with fewer than two characters");

  a_char_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_end) |->
      (out_char_value >= 8'h20 && out_char_value <= 8'h7E && !out_keep &&
       out_kept_length != 8'd0 && out_genre_form == id3_pkg::FORM_TEXT))
    else $error("malformed character record");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == id3_pkg::PH_DONE && !(acc && in_start_of_file)) |=>
      (phase_r == id3_pkg::PH_DONE))
    else $error("left done phase without start of file");

endmodule

FILE: sim/testbench.sv
module testbench;

  localparam int ITEM_BUDGET  = 750;
  localparam int LONG_IMG_LEN = 300;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 12;

  typedef logic [7:0] byte_q_t[$];

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_start_of_file;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_field_kind;
  logic [4:0]  out_char_pos;
  logic [7:0]  out_char_value;
  logic        out_is_end;
  logic        out_keep;
  logic [7:0]  out_kept_length;
  logic [1:0]  out_genre_form;
  logic [6:0]  out_genre_id;

  id3_tag_field_extractor u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_field_kind   (out_field_kind),
    .out_char_pos     (out_char_pos),
    .out_char_value   (out_char_value),
    .out_is_end       (out_is_end),
    .out_keep         (out_keep),
    .out_kept_length  (out_kept_length),
    .out_genre_form   (out_genre_form),
    .out_genre_id     (out_genre_id)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  logic [11:0]        region_lim;
  id3_pkg::phase_t    scan_ph;
  logic [11:0]        byte_cnt;
  logic [39:0]        tag_chars;
  int                 tag_len;
  logic [7:0]         body_left;
  logic [7:0]         kept_cnt;
  logic [31:0]        lead_chars;
  logic [1:0]         frame_kind;
  id3_pkg::out_rec_t  field_rec_q[$];

  int sent_cnt    = 0;
  int live_bytes  = 0;
  int char_recs   = 0;
  int end_recs    = 0;
  int kept_recs   = 0;
  int genre_codes = 0;
  int region_sets = 0;
  int bad_cnt     = 0;
  int cycle_cnt   = 0;
  int burst_left  = 0;

  byte_q_t img;
  byte_q_t none;

  function automatic void clear_frame_state();
    tag_chars  = '0;
    tag_len    = 0;
    body_left  = '0;
    kept_cnt   = '0;
    lead_chars = '0;
    frame_kind = id3_pkg::KIND_NONE;
  endfunction

  function automatic logic [1:0] tag_kind();
    if (tag_len != 3) return id3_pkg::KIND_NONE;
    case (tag_chars)
      id3_pkg::TAG_TT2: return id3_pkg::KIND_TITLE;
      id3_pkg::TAG_TP1: return id3_pkg::KIND_ARTIST;
      id3_pkg::TAG_TCO: return id3_pkg::KIND_GENRE;
      default:          return id3_pkg::KIND_NONE;
    endcase
  endfunction

  function automatic bit dec_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic void close_field();
    id3_pkg::out_rec_t r;
    logic [7:0]        c0;
    logic [7:0]        c1;
    logic [7:0]        c2;
    logic [7:0]        c3;
    if (frame_kind == id3_pkg::KIND_NONE) return;
    {c3, c2, c1, c0} = lead_chars;
    r = '0;
    r.field_kind  = frame_kind;
    r.is_end      = 1'b1;
    r.keep        = kept_cnt >= 8'd2;
    r.kept_length = kept_cnt;
    if (frame_kind == id3_pkg::KIND_GENRE && c0 == "(" && dec_digit(c1)) begin
      if (dec_digit(c2) && c3 == ")") begin
        r.genre_form = id3_pkg::FORM_TWO;
        r.genre_id   = 7'((c1 - 8'h30) * 10 + (c2 - 8'h30));
      end else if (c2 == ")") begin
        r.genre_form = id3_pkg::FORM_ONE;
        r.genre_id   = 7'(c1 - 8'h30);
      end
    end
    if (r.genre_form != id3_pkg::FORM_TEXT) genre_codes++;
    if (r.keep) kept_recs++;
    end_recs++;
    field_rec_q.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic sof);
    id3_pkg::out_rec_t r;
    logic [7:0]        pos;
    if (sof) begin
      scan_ph  = id3_pkg::PH_HEADER;
      byte_cnt = '0;
      clear_frame_state();
    end
    if (scan_ph == id3_pkg::PH_DONE) return;
    if (scan_ph == id3_pkg::PH_TAG && tag_len == 0 && byte_cnt >= region_lim) begin
      scan_ph = id3_pkg::PH_DONE;
      return;
    end
    live_bytes++;
    case (scan_ph)
      id3_pkg::PH_HEADER: begin
        if (byte_cnt + 1 >= id3_pkg::HEADER_LEN) scan_ph = id3_pkg::PH_TAG;
      end
      id3_pkg::PH_TAG: begin
        if (b == 8'h00) begin
          scan_ph = id3_pkg::PH_OPTZERO;
        end else begin
          tag_chars[8*tag_len +: 8] = b;
          tag_len++;
          if (tag_len >= id3_pkg::TAG_MAX) scan_ph = id3_pkg::PH_SKIP;
        end
      end
      id3_pkg::PH_SKIP: scan_ph = id3_pkg::PH_OPTZERO;
      id3_pkg::PH_OPTZERO, id3_pkg::PH_SIZE: begin
        if (scan_ph == id3_pkg::PH_OPTZERO && b == 8'h00) begin
          scan_ph = id3_pkg::PH_SIZE;
        end else begin
          frame_kind = tag_kind();
          if (b == 8'h00) begin
            close_field();
            clear_frame_state();
            scan_ph = id3_pkg::PH_TAG;
          end else begin
            body_left = b;
            scan_ph   = id3_pkg::PH_CONTENT;
          end
        end
      end
      default: begin
        if (b >= 8'h20 && b <= 8'h7E) begin
          pos = kept_cnt;
          if (pos < 4) lead_chars[8*pos +: 8] = b;
          if (kept_cnt < id3_pkg::KEPT_MAX) kept_cnt++;
          if (frame_kind != id3_pkg::KIND_NONE && pos < id3_pkg::NAME_MAX) begin
            r = '0;
            r.field_kind  = frame_kind;
            r.char_pos    = pos[4:0];
            r.char_value  = b;
            r.kept_length = kept_cnt;
            field_rec_q.push_back(r);
            char_recs++;
          end
        end
        if (body_left > 0) body_left--;
        if (body_left == 0) begin
          close_field();
          clear_frame_state();
          scan_ph = id3_pkg::PH_TAG;
        end
      end
    endcase
    if (byte_cnt < id3_pkg::COUNT_MAX) byte_cnt++;
  endfunction

  // file image builders
  function automatic byte_q_t as_bytes(input string s);
    byte_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    return q;
  endfunction

  function automatic void add_header();
    img.delete();
    repeat (id3_pkg::HEADER_LEN) img.push_back(8'($urandom));
  endfunction

  function automatic void add_frame(input byte_q_t tag, input bit opt_zero,
                                    input byte_q_t body);
    foreach (tag[i]) img.push_back(tag[i]);
    if (tag.size() >= id3_pkg::TAG_MAX) img.push_back(8'($urandom));
    else img.push_back(8'h00);
    if (opt_zero || body.size() == 0) img.push_back(8'h00);
    img.push_back(8'(body.size()));
    foreach (body[i]) img.push_back(body[i]);
  endfunction

  function automatic byte_q_t rand_body(input int n);
    byte_q_t q;
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) q.push_back(8'($urandom_range(32, 126)));
      else q.push_back(8'($urandom));
    end
    return q;
  endfunction

  function automatic byte_q_t genre_body();
    byte_q_t q;
    q.push_back("(");
    q.push_back(8'($urandom_range(8'h30, 8'h39)));
    case ($urandom_range(0, 5))
      0: q.push_back(")");
      1: begin
        q.push_back(8'($urandom_range(8'h30, 8'h39)));
        q.push_back(")");
      end
      2: q.push_back(8'($urandom_range(8'h30, 8'h39)));
      3: begin
        q.push_back("a");
        q.push_back(")");
      end
      4: begin
        q[0] = "[";
        q.push_back(")");
      end
      default: repeat (3) q.push_back(8'($urandom_range(8'h30, 8'h39)));
    endcase
    q = {q, rand_body($urandom_range(0, 4))};
    return q;
  endfunction

  function automatic void add_rand_frame();
    byte_q_t tag;
    byte_q_t body;
    int      r;
    int      n;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      case ($urandom_range(0, 2))
        0:       tag = as_bytes("TT2");
        1:       tag = as_bytes("TP1");
        default: tag = as_bytes("TCO");
      endcase
    end else if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       tag = as_bytes("TT");
        1:       tag = as_bytes("TT2X");
        2:       tag = as_bytes("TP2");
        default: tag = as_bytes("TCOO");
      endcase
    end else if (r < 85) begin
      repeat ($urandom_range(1, id3_pkg::TAG_MAX)) tag.push_back(8'($urandom_range(1, 255)));
    end
    if (tag.size() == 3 && tag[2] == "O" && $urandom_range(0, 1) == 1) begin
      body = genre_body();
    end else begin
      r = $urandom_range(0, 99);
      n = r < 80 ? $urandom_range(0, 12) : r < 96 ? $urandom_range(13, 60)
                                                  : $urandom_range(61, 255);
      body = rand_body(n);
    end
    add_frame(tag, 1'($urandom_range(0, 1)), body);
  endfunction

  // input side
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_start_of_file <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, sof);
    sent_cnt++;
    burst_left--;
  endtask

  task automatic send_img(input int sof_at = -1);
    foreach (img[i]) send_byte(img[i], i == 0 || i == sof_at);
  endtask

  task automatic wait_idle();
    in_valid         <= 1'b0;
    in_start_of_file <= 1'b0;
    @(posedge clk);
    while (field_rec_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_region(input logic [11:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    region_lim = v;
    region_sets++;
  endtask

  // output side
  initial begin
    int mode;
    int hold;
    out_stall <= 1'b0;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(50, 300);
      end
      hold--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (hold % 4 != 0);
      endcase
    end
  end

  task automatic report_bad(input string what, input id3_pkg::out_rec_t want,
                            input id3_pkg::out_rec_t got);
    bad_cnt++;
    if (bad_cnt <= 10) begin
      $display("%s at cycle %0d", what, cycle_cnt);
      $display("  expected kind=%0d pos=%0d ch=%02h end=%0b keep=%0b len=%0d form=%0d id=%0d",
               want.field_kind, want.char_pos, want.char_value, want.is_end, want.keep,
               want.kept_length, want.genre_form, want.genre_id);
      $display("  actual   kind=%0d pos=%0d ch=%02h end=%0b keep=%0b len=%0d form=%0d id=%0d",
               got.field_kind, got.char_pos, got.char_value, got.is_end, got.keep,
               got.kept_length, got.genre_form, got.genre_id);
    end
  endtask

  always @(posedge clk) begin
    id3_pkg::out_rec_t want;
    id3_pkg::out_rec_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.field_kind  = out_field_kind;
      got.char_pos    = out_char_pos;
      got.char_value  = out_char_value;
      got.is_end      = out_is_end;
      got.keep        = out_keep;
      got.kept_length = out_kept_length;
      got.genre_form  = out_genre_form;
      got.genre_id    = out_genre_id;
      if (field_rec_q.size() == 0) begin
        report_bad("unexpected transaction", '0, got);
      end else begin
        want = field_rec_q.pop_front();
        if (got !== want) report_bad("field mismatch", want, got);
      end
    end
  end

  // tests
  task automatic test_basic_frames();
    byte_q_t odd;
    add_header();
    add_frame(as_bytes("TT2"), 1'b1, as_bytes("Hi"));
    odd = as_bytes("A");
    odd.push_back(8'h1F);
    odd.push_back(8'h7F);
    odd.push_back(8'hFF);
    odd.push_back(8'h00);
    odd.push_back(8'h20);
    odd.push_back(8'h7E);
    add_frame(as_bytes("TP1"), 1'b0, odd);
    add_frame(as_bytes("TCO"), 1'b0, as_bytes("(7)"));
    add_frame(as_bytes("TCO"), 1'b1, as_bytes("(42)Pop"));
    add_frame(as_bytes("TCO"), 1'b0, as_bytes("(4x"));
    add_frame(as_bytes("TT2"), 1'b1, none);
    add_frame(as_bytes("TP1"), 1'b0, as_bytes("Z"));
    send_img();
  endtask

  task automatic test_tag_edges();
    add_header();
    add_frame(none, 1'b0, as_bytes("zz"));
    add_frame(as_bytes("ABCDE"), 1'b0, as_bytes("no"));
    add_frame(as_bytes("TT2"), 1'b0, as_bytes("ok"));
    add_frame(as_bytes("TXX"), 1'b1, as_bytes("abc"));
    add_frame(as_bytes("TP1"), 1'b0, as_bytes("cut here"));
    img = img[0:img.size()-4];
    send_img();
    // restart in the middle of a frame
    add_header();
    add_frame(as_bytes("TT2"), 1'b0, as_bytes("new"));
    send_img();
  endtask

  task automatic test_region_limits();
    set_region(12'd10);
    add_header();
    add_frame(as_bytes("TT2"), 1'b0, as_bytes("xyz"));
    send_img();
    set_region(12'd11);
    add_header();
    add_frame(as_bytes("TT2"), 1'b0, as_bytes("abcd"));
    add_frame(as_bytes("TP1"), 1'b0, as_bytes("efg"));
    send_img();
  endtask

  task automatic test_long_file();
    byte_q_t body;
    set_region(id3_pkg::COUNT_MAX);
    add_header();
    repeat (255) body.push_back(8'($urandom_range(32, 126)));
    add_frame(as_bytes("TT2"), 1'b0, body);
    while (img.size() < LONG_IMG_LEN) add_rand_frame();
    send_img();
  endtask

  task automatic test_random_files();
    int pick;
    int sof_at;
    while (sent_cnt < ITEM_BUDGET) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 9);
        set_region(pick == 0 ? 12'd10 : pick == 1 ? id3_pkg::REGION_RESET
                 : pick == 2 ? id3_pkg::COUNT_MAX : 12'($urandom_range(11, 250)));
      end
      add_header();
      pick = $urandom_range(0, 99);
      if (pick < 10) repeat ($urandom_range(1, 60)) img.push_back(8'($urandom));
      else repeat ($urandom_range(1, 8)) add_rand_frame();
      if (pick >= 10 && pick < 25) img = img[0:$urandom_range(0, img.size() - 1)];
      sof_at = ($urandom_range(0, 29) == 0) ? $urandom_range(1, img.size() - 1) : -1;
      send_img(sof_at);
    end
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             field_rec_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_data_byte     <= '0;
    in_start_of_file <= 1'b0;
    region_lim = id3_pkg::REGION_RESET;
    scan_ph    = id3_pkg::PH_HEADER;
    byte_cnt   = '0;
    clear_frame_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_frames();
    test_tag_edges();
    test_region_limits();
    test_long_file();
    test_random_files();
    wait_idle();

    $display("sent %0d bytes (%0d parsed) over %0d region settings in %0d cycles", sent_cnt,
             live_bytes, region_sets, cycle_cnt);
    $display("checked %0d characters and %0d end records (%0d committed, %0d genre codes)",
             char_recs, end_recs, kept_recs, genre_codes);
    if (bad_cnt == 0 && field_rec_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", bad_cnt, field_rec_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/id3_pkg.sv
rtl/id3_tag_field_extractor.sv
sim/testbench.sv
